// ===== rtl/ddg_pkg.sv =====
// shared types and constants of the tree walk sampler
package ddg_pkg;

    localparam int MAX_LEVELS_DEF = 128;
    localparam int MAX_ATOMS_DEF  = 256;
    localparam int LEAF_STORE_DEF = 4096;
    localparam int LIMIT_RST      = 128;

    localparam int SLOT_W  = 12;
    localparam int LEAVES_W = 9;
    localparam int NODES_W = 32;
    localparam int LEVEL_W = 7;
    localparam int ATOM_IN_W = 8;
    localparam int CFG_W   = 8;
    localparam int WORD_W  = 32;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        KIND_LEVEL = 2'd0,
        KIND_LEAF  = 2'd1,
        KIND_BIT   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [SLOT_W-1:0]   first_slot;
        logic [LEAVES_W-1:0] leaf_cnt;
        logic [NODES_W-1:0]  node_cnt;
    } t_level_rec;

    typedef struct packed {
        logic emit_leaf;
        logic emit_ovr;
    } t_step_flags;

endpackage

// ===== rtl/ddg_tree_discrete_sampler_core.sv =====
// top level of the tree walk sampler: input stage, table memories, walk state, result stage
//
// The sampler takes one transfer per clock, of any kind, unless a held result stalls it; a random
// bit that ends a walk passes the input and result stage registers. Per-level records sit in a
// level memory that is read every cycle at the level the walk will be on next, so the record is
// ready when the next bit arrives; a record written in the cycle of that read is forwarded.
// The leaf memory is read once a leaf is hit and its registered output feeds the result.
// Load transfers (level records, leaf entries) leave the walk in progress untouched.
// Level, leaf and atom depths are assumed powers of two; memories hold no reset values.
module ddg_tree_discrete_sampler_core #(
    parameter int MAX_LEVELS = ddg_pkg::MAX_LEVELS_DEF,
    parameter int MAX_ATOMS  = ddg_pkg::MAX_ATOMS_DEF,
    parameter int LEAF_STORE = ddg_pkg::LEAF_STORE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ddg_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // level_number, first_leaf_slot, leaves_at_level, nodes_at_level,
    // leaf_slot, atom_value, random_bit, zero fill
    input  logic [ddg_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic [ddg_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sample_index
    output logic [ddg_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // overrun
    output logic                            m_axis_tuser
);
    import ddg_pkg::*;

    localparam int LVL_AW  = $clog2(MAX_LEVELS);
    localparam int LEAF_AW = $clog2(LEAF_STORE);
    localparam int ATOM_W  = ($clog2(MAX_ATOMS) < ATOM_IN_W) ? $clog2(MAX_ATOMS) : ATOM_IN_W;
    localparam int LIM_W   = LVL_AW + 1;
    localparam int PAY_W   = 81;
    localparam int LIM_RST = (LIMIT_RST > MAX_LEVELS) ? MAX_LEVELS : LIMIT_RST;

    // input stage
    logic              r_in_valid;
    t_kind             r_in_kind;
    logic [PAY_W-1:0]  r_in_data;

    logic              exec;
    logic              is_level;
    logic              is_leaf;
    logic              is_bit;

    // walk state
    logic [WORD_W-1:0] r_offset;
    logic [WORD_W-1:0] r_span;
    logic [LVL_AW-1:0] r_level;
    logic [LIM_W-1:0]  r_limit;
    logic [LVL_AW-1:0] n_level;
    logic [WORD_W-1:0] cfg_wide;
    logic [WORD_W-1:0] n_limit_wide;

    // level memory and forwarding
    t_level_rec        wr_rec;
    t_level_rec        lvl_q;
    t_level_rec        r_byp_rec;
    logic              r_byp_hit;
    t_level_rec        cur_rec;
    logic [WORD_W-1:0] lvl_wide;
    logic [LVL_AW-1:0] lvl_waddr;
    logic              lvl_we;

    // leaf memory
    logic [WORD_W-1:0]  slot_wide;
    logic [LEAF_AW-1:0] leaf_waddr;
    logic [ATOM_W-1:0]  leaf_wdata;
    logic [ATOM_W-1:0]  leaf_q;
    logic               leaf_we;
    logic               leaf_re;

    // step results
    logic [WORD_W-1:0]  st_offset;
    logic [WORD_W-1:0]  st_span;
    logic [LVL_AW-1:0]  st_level;
    logic [LEAF_AW-1:0] st_leaf_addr;
    t_step_flags        st_flags;
    logic               exec_emit;

    // result stage
    logic              r_res_valid;
    logic              r_res_ovr;

    assign exec          = r_in_valid && (!r_res_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || exec;
    assign is_level      = r_in_kind == KIND_LEVEL;
    assign is_leaf       = r_in_kind == KIND_LEAF;
    assign is_bit        = r_in_kind == KIND_BIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= t_kind'(s_axis_tuser);
            r_in_data <= s_axis_tdata[PAY_W-1:0];
        end
    end

    // level record and leaf entry write
    always_comb begin
        lvl_wide          = WORD_W'(r_in_data[6:0]);
        lvl_waddr         = lvl_wide[LVL_AW-1:0];
        wr_rec.first_slot = r_in_data[18:7];
        wr_rec.leaf_cnt   = r_in_data[27:19];
        wr_rec.node_cnt   = r_in_data[59:28];
        lvl_we            = exec && is_level;
        slot_wide         = WORD_W'(r_in_data[71:60]);
        leaf_waddr        = slot_wide[LEAF_AW-1:0];
        leaf_wdata        = r_in_data[72 +: ATOM_W];
        leaf_we           = exec && is_leaf;
    end

    ddg_ram #(
        .WIDTH ($bits(t_level_rec)),
        .DEPTH (MAX_LEVELS)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (wr_rec),
        .i_re    (1'b1),
        .i_raddr (n_level),
        .o_rdata (lvl_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= lvl_we && (lvl_waddr == n_level);
        end
        r_byp_rec <= wr_rec;
    end

    assign cur_rec = r_byp_hit ? r_byp_rec : lvl_q;

    ddg_step #(
        .MAX_LEVELS (MAX_LEVELS),
        .LEAF_STORE (LEAF_STORE)
    ) u_step (
        .i_offset    (r_offset),
        .i_span      (r_span),
        .i_level     (r_level),
        .i_limit     (r_limit),
        .i_rec       (cur_rec),
        .i_bit       (r_in_data[80]),
        .o_offset    (st_offset),
        .o_span      (st_span),
        .o_level     (st_level),
        .o_leaf_addr (st_leaf_addr),
        .o_flags     (st_flags)
    );

    assign exec_emit = exec && is_bit && (st_flags.emit_leaf || st_flags.emit_ovr);
    assign leaf_re   = exec && is_bit && st_flags.emit_leaf;
    assign n_level   = (exec && is_bit) ? st_level : r_level;

    ddg_ram #(
        .WIDTH (ATOM_W),
        .DEPTH (LEAF_STORE)
    ) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_re    (leaf_re),
        .i_raddr (st_leaf_addr),
        .o_rdata (leaf_q)
    );

    // level limit, clamped on write
    always_comb begin
        cfg_wide = WORD_W'(i_cfg_wdata);
        if (cfg_wide == '0) begin
            n_limit_wide = WORD_W'(1);
        end else if (cfg_wide > WORD_W'(MAX_LEVELS)) begin
            n_limit_wide = WORD_W'(MAX_LEVELS);
        end else begin
            n_limit_wide = cfg_wide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_span   <= WORD_W'(1);
            r_level  <= '0;
            r_limit  <= LIM_W'(LIM_RST);
        end else begin
            if (exec && is_bit) begin
                r_offset <= st_offset;
                r_span   <= st_span;
                r_level  <= st_level;
            end
            if (i_cfg_we) begin
                r_limit <= n_limit_wide[LIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (exec_emit) begin
            r_res_valid <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_res_valid <= 1'b0;
        end
        if (exec_emit) begin
            r_res_ovr <= st_flags.emit_ovr;
        end
    end

    assign m_axis_tvalid = r_res_valid;
    assign m_axis_tuser  = r_res_ovr;
    assign m_axis_tdata  = r_res_ovr ? '0 : M_TDATA_W'(leaf_q);

    a_restart_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_emit |=> (r_offset == '0) && (r_span == WORD_W'(1)) && (r_level == '0))
        else $error("walk not restarted after a result");

    a_offset_within_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= r_span)
        else $error("path offset exceeds node span");

    a_level_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && is_bit && !exec_emit) |=> (LIM_W'(r_level) < r_limit))
        else $error("walk level at or beyond the level limit");

endmodule

// ===== rtl/ddg_ram.sv =====
// generic single write port memory with registered read
module ddg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ddg_step.sv =====
// one step of the tree walk: doubling, level threshold, leaf hit, overrun and descent
module ddg_step #(
    parameter int MAX_LEVELS = ddg_pkg::MAX_LEVELS_DEF,
    parameter int LEAF_STORE = ddg_pkg::LEAF_STORE_DEF
) (
    input  logic [ddg_pkg::WORD_W-1:0]     i_offset,
    input  logic [ddg_pkg::WORD_W-1:0]     i_span,
    input  logic [$clog2(MAX_LEVELS)-1:0]  i_level,
    input  logic [$clog2(MAX_LEVELS):0]    i_limit,
    input  ddg_pkg::t_level_rec            i_rec,
    input  logic                           i_bit,
    output logic [ddg_pkg::WORD_W-1:0]     o_offset,
    output logic [ddg_pkg::WORD_W-1:0]     o_span,
    output logic [$clog2(MAX_LEVELS)-1:0]  o_level,
    output logic [$clog2(LEAF_STORE)-1:0]  o_leaf_addr,
    output ddg_pkg::t_step_flags           o_flags
);
    import ddg_pkg::*;

    localparam int LVL_AW  = $clog2(MAX_LEVELS);
    localparam int LEAF_AW = $clog2(LEAF_STORE);

    logic [WORD_W:0]   dbl_off;
    logic [WORD_W-1:0] off_d;
    logic [WORD_W-1:0] span_d;
    logic [WORD_W-1:0] leaves;
    logic [WORD_W-1:0] off_s;
    logic [WORD_W-1:0] span_s;
    logic [WORD_W-1:0] addr_sum;
    logic [LVL_AW:0]   nxt_lvl;
    logic              reached;
    logic              hit;
    logic              ovr;

    always_comb begin
        dbl_off  = {i_offset, i_bit};
        off_d    = dbl_off[WORD_W] ? '1 : dbl_off[WORD_W-1:0];
        span_d   = i_span[WORD_W-1] ? '1 : {i_span[WORD_W-2:0], 1'b0};
        leaves   = WORD_W'(i_rec.leaf_cnt);
        reached  = span_d >= i_rec.node_cnt;
        hit      = reached && (off_d < leaves);
        off_s    = reached ? off_d - leaves : off_d;
        span_s   = reached ? span_d - leaves : span_d;
        nxt_lvl  = {1'b0, i_level} + (LVL_AW+1)'(1);
        ovr      = !hit && (nxt_lvl >= i_limit);
        addr_sum = WORD_W'(i_rec.first_slot) + off_d;

        o_flags.emit_leaf = hit;
        o_flags.emit_ovr  = ovr;
        o_leaf_addr       = addr_sum[LEAF_AW-1:0];
        if (hit || ovr) begin
            o_offset = '0;
            o_span   = WORD_W'(1);
            o_level  = '0;
        end else begin
            o_offset = off_s;
            o_span   = span_s;
            o_level  = nxt_lvl[LVL_AW-1:0];
        end
    end
endmodule

// ===== bench/tb_ddg_tree_discrete_sampler_core.sv =====
// testbench for the tree walk sampler core: directed cases, random tree loads and random bit streams
module tb_ddg_tree_discrete_sampler_core;
    import ddg_pkg::*;

    localparam int N_LEVELS = MAX_LEVELS_DEF;
    localparam int N_SLOTS = LEAF_STORE_DEF;
    localparam logic [WORD_W-1:0] WORD_FULL = 32'hFFFF_FFFF;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [1:0]           kind;
        logic [LEVEL_W-1:0]   level_no;
        logic [SLOT_W-1:0]    first_slot;
        logic [LEAVES_W-1:0]  leaves;
        logic [NODES_W-1:0]   nodes;
        logic [SLOT_W-1:0]    leaf_slot;
        logic [ATOM_IN_W-1:0] atom;
        logic                 bit_in;
    } t_sampler_item;

    typedef struct {
        logic [M_TDATA_W-1:0] atom_idx;
        logic                 ovr;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    t_sampler_item feed_q[$];
    t_outcome outcome_q[$];
    t_sampler_item on_bus;
    bit leaf_known[N_SLOTS];
    int queued_count = 0;
    int error_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit idle_on = 1'b1;

    // walk model state
    logic [SLOT_W-1:0]    lvl_first[N_LEVELS];
    logic [LEAVES_W-1:0]  lvl_leaves[N_LEVELS];
    logic [NODES_W-1:0]   lvl_nodes[N_LEVELS];
    logic [ATOM_IN_W-1:0] leaf_atom[N_SLOTS];
    logic [WORD_W-1:0]    path_off = '0;
    logic [WORD_W-1:0]    node_span = 32'd1;
    logic [7:0]           walk_level = '0;
    logic [CFG_W-1:0]     levels_cfg = 8'(LIMIT_RST);

    ddg_tree_discrete_sampler_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [S_TDATA_W-1:0] pack_item(input t_sampler_item it);
        return {7'd0, it.bit_in, it.atom, it.leaf_slot, it.nodes, it.leaves, it.first_slot,
                it.level_no};
    endfunction

    function automatic t_sampler_item fresh_item(input logic [1:0] kind);
        t_sampler_item it;
        it.kind = kind;
        it.level_no = LEVEL_W'($urandom());
        it.first_slot = SLOT_W'($urandom());
        it.leaves = LEAVES_W'($urandom());
        it.nodes = $urandom();
        it.leaf_slot = SLOT_W'($urandom());
        it.atom = ATOM_IN_W'($urandom());
        it.bit_in = 1'($urandom());
        return it;
    endfunction

    function automatic logic [NODES_W-1:0] noise_nodes();
        case ($urandom_range(3, 0))
            0: return '0;
            1: return WORD_FULL;
            2: return $urandom_range(64, 0);
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic rewind_walk();
        path_off = '0;
        node_span = 32'd1;
        walk_level = '0;
    endtask

    task automatic walk_tree_step(input t_sampler_item it);
        logic [LEVEL_W-1:0] lv;
        logic [WORD_W:0] wide;
        logic [7:0] limit;
        logic [SLOT_W-1:0] addr;
        t_outcome res;
        bit hit;
        case (it.kind)
            KIND_LEVEL: begin
                lvl_first[it.level_no] = it.first_slot;
                lvl_leaves[it.level_no] = it.leaves;
                lvl_nodes[it.level_no] = it.nodes;
            end
            KIND_LEAF: begin
                leaf_atom[it.leaf_slot] = it.atom;
            end
            KIND_BIT: begin
                lv = walk_level[LEVEL_W-1:0];
                limit = levels_cfg;
                if (limit == 8'd0) limit = 8'd1;
                if (limit > 8'(N_LEVELS)) limit = 8'(N_LEVELS);
                wide = {path_off, it.bit_in};
                path_off = wide[WORD_W] ? WORD_FULL : wide[WORD_W-1:0];
                wide = {node_span, 1'b0};
                node_span = wide[WORD_W] ? WORD_FULL : wide[WORD_W-1:0];
                hit = 1'b0;
                if (node_span >= lvl_nodes[lv]) begin
                    if (path_off < lvl_leaves[lv]) begin
                        addr = lvl_first[lv] + path_off[SLOT_W-1:0];
                        res.atom_idx = leaf_atom[addr];
                        res.ovr = 1'b0;
                        outcome_q = {outcome_q, res};
                        hit = 1'b1;
                    end else begin
                        node_span = node_span - lvl_leaves[lv];
                        path_off = path_off - lvl_leaves[lv];
                    end
                end
                if (hit) begin
                    rewind_walk();
                end else begin
                    walk_level = {1'b0, lv} + 8'd1;
                    if (walk_level >= limit) begin
                        res.atom_idx = '0;
                        res.ovr = 1'b1;
                        outcome_q = {outcome_q, res};
                        rewind_walk();
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_leaf(input int slot, input int atom);
        t_sampler_item it;
        it = fresh_item(KIND_LEAF);
        it.leaf_slot = slot[SLOT_W-1:0];
        it.atom = atom[ATOM_IN_W-1:0];
        feed_q = {feed_q, it};
        leaf_known[slot % N_SLOTS] = 1'b1;
        queued_count++;
    endtask

    // leaf slots of a level are always written before its record
    task automatic queue_level(input int lv, input int first, input int leaves,
                               input logic [NODES_W-1:0] nodes);
        t_sampler_item it;
        for (int k = 0; k < leaves; k++)
            if (!leaf_known[(first + k) % N_SLOTS])
                queue_leaf((first + k) % N_SLOTS, $urandom_range(255, 0));
        it = fresh_item(KIND_LEVEL);
        it.level_no = lv[LEVEL_W-1:0];
        it.first_slot = first[SLOT_W-1:0];
        it.leaves = leaves[LEAVES_W-1:0];
        it.nodes = nodes;
        feed_q = {feed_q, it};
        queued_count++;
    endtask

    task automatic queue_bit(input logic b);
        t_sampler_item it;
        it = fresh_item(KIND_BIT);
        it.bit_in = b;
        feed_q = {feed_q, it};
        queued_count++;
    endtask

    task automatic queue_unused_kind();
        feed_q = {feed_q, fresh_item(KIND_NONE)};
    endtask

    // well-formed tree: each level's node count is twice the previous level's internal nodes
    task automatic queue_tree(input int depth);
        longint unsigned nodes;
        logic [NODES_W-1:0] nodes_w;
        int cap;
        int leaves;
        nodes = 2;
        for (int l = 0; l < depth; l++) begin
            cap = (nodes < 24) ? int'(nodes) : 24;
            leaves = $urandom_range(cap, cap / 2);
            nodes_w = (nodes > 64'hFFFF_FFFF) ? WORD_FULL : nodes[NODES_W-1:0];
            queue_level(l, $urandom_range(N_SLOTS - 1, 0), leaves, nodes_w);
            nodes = 2 * (nodes - leaves);
            if (nodes > 64'hFFFF_FFFF) nodes = 64'hFFFF_FFFF;
        end
    endtask

    // sampled at the falling edge so that queue and bus state are settled
    task automatic wait_quiet();
        @(negedge i_clk);
        while (feed_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_levels(input logic [CFG_W-1:0] v);
        wait_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        levels_cfg = v;
    endtask

    // stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) walk_tree_step(on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (feed_q.size() != 0) begin
                    on_bus = feed_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pack_item(on_bus);
                    s_axis_tuser <= on_bus.kind;
                    if (idle_on && $urandom_range(9, 0) == 0) send_gap = $urandom_range(12, 1);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0d overrun %0b",
                                              m_axis_tdata, m_axis_tuser));
                end else begin
                    want = outcome_q.pop_front();
                    if (m_axis_tdata !== want.atom_idx)
                        report_mismatch($sformatf("sample_index %0d, want %0d",
                                                  m_axis_tdata, want.atom_idx));
                    if (m_axis_tuser !== want.ovr)
                        report_mismatch($sformatf("overrun %0b, want %0b",
                                                  m_axis_tuser, want.ovr));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(7, 0) == 0) recv_stall = $urandom_range(12, 1);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int mark;
        int pick;
        int eff;
        int depth;
        int nbits;
        int roll;
        logic [CFG_W-1:0] lvl_val;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every level passes through, the last one holds 256 leaves
        for (int lv = 0; lv < N_LEVELS; lv++)
            queue_level(lv, $urandom_range(N_SLOTS - 1, 0), (lv == N_LEVELS - 1) ? 256 : 0,
                        WORD_FULL);
        queue_unused_kind();
        // all ones: offset and span saturate, overrun past the last level
        repeat (N_LEVELS) queue_bit(1'b1);

        write_levels(8'd0);
        queue_bit(1'b0);
        queue_leaf(N_SLOTS - 1, 255);
        queue_leaf(0, 0);
        queue_level(0, N_SLOTS - 1, 2, '0);
        queue_bit(1'b1);
        queue_bit(1'b0);
        queue_bit(1'b1);
        queue_unused_kind();

        pick = 0;
        mark = queued_count;
        while (queued_count - mark < RANDOM_ITEMS) begin
            case (pick)
                0: lvl_val = 8'd255;
                1: lvl_val = 8'd1;
                2: lvl_val = 8'd128;
                default: lvl_val = ($urandom_range(4, 0) == 0) ? CFG_W'($urandom_range(255, 0))
                                                             : CFG_W'($urandom_range(24, 2));
            endcase
            pick++;
            write_levels(lvl_val);
            idle_on = (queued_count - mark < RANDOM_ITEMS * 85 / 100) &&
                      ($urandom_range(3, 0) != 0);
            eff = (lvl_val == 0) ? 1 : ((lvl_val > N_LEVELS) ? N_LEVELS : int'(lvl_val));
            depth = $urandom_range((eff < 16) ? eff : 16, 1);
            queue_tree(depth);
            nbits = $urandom_range(120, 40);
            repeat (nbits) begin
                roll = $urandom_range(99, 0);
                if (roll < 4)
                    queue_level($urandom_range(N_LEVELS - 1, 0), $urandom_range(N_SLOTS - 1, 0),
                                ($urandom_range(3, 0) == 0) ? $urandom_range(511, 0)
                                                            : $urandom_range(16, 0),
                                noise_nodes());
                else if (roll < 8)
                    queue_leaf($urandom_range(N_SLOTS - 1, 0), $urandom_range(255, 0));
                else if (roll < 10)
                    queue_unused_kind();
                else
                    queue_bit($urandom_range(1, 0));
            end
        end

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
